// ----- rtl/kufef_pkg.sv -----
// Package for the Kruskal union-find edge filter: word types, field widths and codes.
// Depends on nothing; used by kruskal_union_find_edge_filter.
package kufef_pkg;

    localparam int VERTEX_BITS = 10;
    localparam int COST_BITS   = 16;
    localparam int TOTAL_BITS  = 32;
    localparam int COUNT_BITS  = 10;
    localparam int ACTIVE_BITS = 11;
    localparam int RANK_BITS   = 4;

    localparam logic [RANK_BITS-1:0]   RANK_MAX  = '1;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;
    localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 11'd1024;

    localparam logic MODE_CLEAR = 1'b0;
    localparam logic MODE_EDGE  = 1'b1;

    localparam logic REG_ACTIVE_VERTICES = 1'b0;

    typedef struct packed {
        logic                        mode;
        logic [VERTEX_BITS-1:0]      first_vertex;
        logic [VERTEX_BITS-1:0]      second_vertex;
        logic signed [COST_BITS-1:0] cost;
    } in_word_t;

    typedef struct packed {
        logic                         joined;
        logic                         bad_vertex;
        logic signed [TOTAL_BITS-1:0] tree_cost_total;
        logic [COUNT_BITS-1:0]        tree_edge_count;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND,
        ST_COMP_RD,
        ST_COMP,
        ST_UNION,
        ST_RAISE,
        ST_RESULT
    } state_t;

endpackage

// ----- rtl/kruskal_union_find_edge_filter.sv -----
// Kruskal edge filter over a disjoint-set forest held in one single-port-read memory.
// Depends on kufef_pkg for the word types, widths, codes and sequencer states.
//
//   Channel   Direction  Handshake                  Word
//   in        input      in_valid / in_ready        kufef_pkg::in_word_t
//   out       output     out_valid / out_ready      kufef_pkg::out_word_t
//   apb       input      psel, penable, pready      active_vertices at address 0
//
// An edge word runs two finds and then a union, and a rank tie can add a rank raise;
// each find walks to the root and again to re-point the path to it, one forest memory
// read per cycle. A clear word rewrites the whole forest before its result, a bad-vertex
// word goes straight to its result, and the forest rewrite that follows reset holds
// the input off.
// A stalled consumer only holds the sequencer once the next result is ready.
module kruskal_union_find_edge_filter #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kufef_pkg::in_word_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kufef_pkg::out_word_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import kufef_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_VERTICES - 1);

    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic [AW-1:0]        parent;
    } entry_t;

    entry_t forest_mem [MAX_VERTICES];
    entry_t rdata_reg;
    logic   mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    entry_t mem_wdata;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic signed [TOTAL_BITS-1:0] cost_total_reg, cost_total_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [ACTIVE_BITS-1:0] active_reg;
    logic [AW-1:0]          sweep_reg, sweep_next;
    logic                   emit_reg, emit_next;

    in_word_t             item_reg, item_next;
    out_word_t            out_reg, out_next;
    logic [AW-1:0]        node_reg, node_next;
    logic [AW-1:0]        start_reg, start_next;
    logic [AW-1:0]        root_reg, root_next;
    logic [AW-1:0]        ru_reg, ru_next;
    logic [RANK_BITS-1:0] rank_cur_reg, rank_cur_next;
    logic [RANK_BITS-1:0] rank_u_reg, rank_u_next;
    logic                 side_reg, side_next;
    logic                 joined_reg, joined_next;
    logic                 bad_reg, bad_next;

    logic in_fire;
    logic bad_in;

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_ACTIVE_VERTICES) ? 32'(active_reg) : '0;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign bad_in = ({1'b0, in_data.first_vertex} >= active_reg)
        || ({1'b0, in_data.second_vertex} >= active_reg)
        || (32'(in_data.first_vertex) >= 32'(MAX_VERTICES))
        || (32'(in_data.second_vertex) >= 32'(MAX_VERTICES));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            forest_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= forest_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_ACTIVE_VERTICES)
        begin
            active_reg <= pwdata[ACTIVE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            out_valid_reg  <= 1'b0;
            cost_total_reg <= '0;
            count_reg      <= '0;
            sweep_reg      <= '0;
            emit_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            cost_total_reg <= cost_total_next;
            count_reg      <= count_next;
            sweep_reg      <= sweep_next;
            emit_reg       <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_reg      <= out_next;
        node_reg     <= node_next;
        start_reg    <= start_next;
        root_reg     <= root_next;
        ru_reg       <= ru_next;
        rank_cur_reg <= rank_cur_next;
        rank_u_reg   <= rank_u_next;
        side_reg     <= side_next;
        joined_reg   <= joined_next;
        bad_reg      <= bad_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cost_total_next = cost_total_reg;
        count_next      = count_reg;
        sweep_next      = sweep_reg;
        emit_next       = emit_reg;
        item_next       = item_reg;
        out_next        = out_reg;
        node_next       = node_reg;
        start_next      = start_reg;
        root_next       = root_reg;
        ru_next         = ru_reg;
        rank_cur_next   = rank_cur_reg;
        rank_u_next     = rank_u_reg;
        side_next       = side_reg;
        joined_next     = joined_reg;
        bad_next        = bad_reg;
        mem_we          = 1'b0;
        mem_waddr       = node_reg;
        mem_wdata       = rdata_reg;
        mem_raddr       = node_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we           = 1'b1;
                mem_waddr        = sweep_reg;
                mem_wdata.rank   = '0;
                mem_wdata.parent = sweep_reg;
                sweep_next       = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ENTRY)
                begin
                    sweep_next = '0;
                    state_next = emit_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    item_next   = in_data;
                    joined_next = 1'b0;
                    bad_next    = 1'b0;
                    if (in_data.mode == MODE_CLEAR)
                    begin
                        cost_total_next = '0;
                        count_next      = '0;
                        sweep_next      = '0;
                        emit_next       = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    else if (bad_in)
                    begin
                        bad_next   = 1'b1;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        side_next  = 1'b0;
                        node_next  = AW'(in_data.first_vertex);
                        start_next = AW'(in_data.first_vertex);
                        state_next = ST_FIND_RD;
                    end
                end
            end
            ST_FIND_RD:
            begin
                state_next = ST_FIND;
            end
            ST_FIND:
            begin
                if (rdata_reg.parent == node_reg)
                begin
                    root_next     = node_reg;
                    rank_cur_next = rdata_reg.rank;
                    node_next     = start_reg;
                    state_next    = ST_COMP_RD;
                end
                else
                begin
                    mem_raddr = rdata_reg.parent;
                    node_next = rdata_reg.parent;
                end
            end
            ST_COMP_RD:
            begin
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                if (node_reg == root_reg)
                begin
                    if (side_reg == 1'b0)
                    begin
                        ru_next     = root_reg;
                        rank_u_next = rank_cur_reg;
                        side_next   = 1'b1;
                        node_next   = AW'(item_reg.second_vertex);
                        start_next  = AW'(item_reg.second_vertex);
                        state_next  = ST_FIND_RD;
                    end
                    else
                    begin
                        state_next = ST_UNION;
                    end
                end
                else
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = node_reg;
                    mem_wdata.rank   = rdata_reg.rank;
                    mem_wdata.parent = root_reg;
                    mem_raddr        = rdata_reg.parent;
                    node_next        = rdata_reg.parent;
                end
            end
            ST_UNION:
            begin
                state_next = ST_RESULT;
                if (ru_reg != root_reg)
                begin
                    joined_next     = 1'b1;
                    cost_total_next = cost_total_reg + TOTAL_BITS'($signed(item_reg.cost));
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    mem_we = 1'b1;
                    if (rank_u_reg > rank_cur_reg)
                    begin
                        mem_waddr        = root_reg;
                        mem_wdata.rank   = rank_cur_reg;
                        mem_wdata.parent = ru_reg;
                    end
                    else
                    begin
                        mem_waddr        = ru_reg;
                        mem_wdata.rank   = rank_u_reg;
                        mem_wdata.parent = root_reg;
                        if (rank_u_reg == rank_cur_reg && rank_cur_reg != RANK_MAX)
                        begin
                            state_next = ST_RAISE;
                        end
                    end
                end
            end
            ST_RAISE:
            begin
                mem_we           = 1'b1;
                mem_waddr        = root_reg;
                mem_wdata.rank   = rank_cur_reg + 1'b1;
                mem_wdata.parent = root_reg;
                state_next       = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.joined          = joined_reg;
                    out_next.bad_vertex      = bad_reg;
                    out_next.tree_cost_total = cost_total_reg;
                    out_next.tree_edge_count = count_reg;
                    out_valid_next           = 1'b1;
                    emit_next                = 1'b0;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
